FILE: src/avr_pkg.sv
// ============================================================================
// avr_pkg - shared constants, widths and sine table for the vector rotator
// Holds the fixed-point widths of every pipeline stage and the quarter-wave
// sine table that is built once at elaboration.
// ============================================================================
package avr_pkg;

    // Field widths
    localparam int CW        = 16;                  // vector component, Q4.12
    localparam int AW        = 16;                  // axis component, Q1.14
    localparam int TW        = 16;                  // sine / cosine, Q1.14
    localparam int ANGLE_W   = 16;
    localparam int PHASE_W   = ANGLE_W - 2;
    localparam int FRAC      = 14;
    localparam int RND_HALF  = 1 << (FRAC - 1);
    localparam int ONE_Q14   = 1 << FRAC;

    // Sine table
    localparam int SINE_N    = 1024;
    localparam int SINE_AW   = $clog2(SINE_N + 1);
    localparam int SINE_W    = FRAC + 1;            // 0 .. 1.0 in Q1.14
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    // Taylor series divisors, (2n) * (2n + 1) for term n
    localparam longint unsigned TAYLOR_DIV [1:12] = '{
        64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // Stage widths
    localparam int PROD_W    = CW + AW;             // axis x vector product
    localparam int DOT_W     = PROD_W + 2;          // sum of three products
    localparam int D_W       = DOT_W + 1 - FRAC;    // rounded dot product
    localparam int CRS_W     = PROD_W + 1;          // difference of two products
    localparam int CR_W      = CRS_W + 1 - FRAC;    // rounded cross component
    localparam int P1_W      = CW + TW;             // v * cos
    localparam int P2_W      = CR_W + TW;           // cross * sin
    localparam int P3_W      = AW + D_W;            // k * (k.v)
    localparam int KD_W      = P3_W + 1 - FRAC;     // rounded k * (k.v)
    localparam int OM_W      = TW + 1;              // 1 - cos
    localparam int P4_W      = KD_W + OM_W;
    localparam int ACC_W     = P4_W + 2;
    localparam int R_W       = ACC_W + 1 - FRAC;

    localparam int LATENCY   = 5;

    // Configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_Z = 2'd2;

    localparam logic signed [AW-1:0] AXIS_X_RST = AW'(ONE_Q14);
    localparam logic signed [AW-1:0] AXIS_Y_RST = '0;
    localparam logic signed [AW-1:0] AXIS_Z_RST = '0;

    localparam logic signed [CW-1:0] OUT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] OUT_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef logic [SINE_W-1:0] sine_tab_t [0:SINE_N];

    // Quarter-wave sine, Q30 Taylor series rounded to Q14
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t         tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        for (int k = 0; k <= SINE_N; k++) begin
            if (k >= SINE_N) begin
                tab[k] = SINE_W'(ONE_Q14);
            end
            else begin
                x    = (PI_HALF_Q30 * longint'(k)) / SINE_N;
                x2   = (x * x) >> 30;
                term = x;
                sum  = 0;
                for (int n = 1; n <= 12; n++) begin
                    if ((n & 1) == 1) begin
                        sum = sum + longint'(term);
                    end
                    else begin
                        sum = sum - longint'(term);
                    end
                    term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                end
                if (sum < 0) begin
                    sum = 0;
                end
                sum = (sum + (longint'(1) << 15)) >>> 16;
                if (sum > ONE_Q14) begin
                    sum = ONE_Q14;
                end
                tab[k] = SINE_W'(sum);
            end
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: src/avr_sine_rom.sv
// ============================================================================
// avr_sine_rom - dual-read quarter-wave sine ROM
// Maps the angle phase to a table index and reads S(i) and S(N-i), both
// registered.
// ============================================================================
module avr_sine_rom
    import avr_pkg::*;
(
    input  logic                clk,
    input  logic [ANGLE_W-1:0]  angle,
    output logic [SINE_W-1:0]   sa,
    output logic [SINE_W-1:0]   sb
);

    localparam int SCL_W = PHASE_W + SINE_AW;

    logic [SCL_W-1:0]   scaled;
    logic [SINE_AW-1:0] idx_a;
    logic [SINE_AW-1:0] idx_b;
    logic [SINE_W-1:0]  sa_reg;
    logic [SINE_W-1:0]  sb_reg;

    // phase * N / 2^14, always below N
    assign scaled = SCL_W'(angle[PHASE_W-1:0]) * SCL_W'(SINE_N);
    assign idx_a  = SINE_AW'(scaled >> PHASE_W);
    assign idx_b  = SINE_AW'(SINE_N) - idx_a;

    always_ff @(posedge clk)
    begin
        sa_reg <= SINE_TAB[idx_a];
        sb_reg <= SINE_TAB[idx_b];
    end

    assign sa = sa_reg;
    assign sb = sb_reg;

endmodule

FILE: src/avr_front.sv
// ============================================================================
// avr_front - axis products, dot and cross terms, sine/cosine select
// Stage one forms the nine axis-by-vector products; stage two sums and
// rounds them and resolves sine and cosine from the quadrant.
// ============================================================================
module avr_front
    import avr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [CW-1:0]    vec_x,
    input  logic signed [CW-1:0]    vec_y,
    input  logic signed [CW-1:0]    vec_z,
    input  logic [1:0]              quad,
    input  logic signed [AW-1:0]    axis_x,
    input  logic signed [AW-1:0]    axis_y,
    input  logic signed [AW-1:0]    axis_z,
    input  logic [SINE_W-1:0]       sa,
    input  logic [SINE_W-1:0]       sb,
    output logic                    out_valid,
    output logic signed [CW-1:0]    out_vx,
    output logic signed [CW-1:0]    out_vy,
    output logic signed [CW-1:0]    out_vz,
    output logic signed [D_W-1:0]   out_d,
    output logic signed [CR_W-1:0]  out_crx,
    output logic signed [CR_W-1:0]  out_cry,
    output logic signed [CR_W-1:0]  out_crz,
    output logic signed [TW-1:0]    out_sin,
    output logic signed [TW-1:0]    out_cos
);

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // Stage one
    logic                     v1_reg;
    logic signed [CW-1:0]     vx1_reg, vy1_reg, vz1_reg;
    quad_t                    quad1_reg;
    logic signed [PROD_W-1:0] kxvx_reg, kyvy_reg, kzvz_reg;
    logic signed [PROD_W-1:0] kyvz_reg, kzvy_reg, kzvx_reg;
    logic signed [PROD_W-1:0] kxvz_reg, kxvy_reg, kyvx_reg;

    // Stage two
    logic                     v2_reg;
    logic signed [CW-1:0]     vx2_reg, vy2_reg, vz2_reg;
    logic signed [D_W-1:0]    d_reg;
    logic signed [CR_W-1:0]   crx_reg, cry_reg, crz_reg;
    logic signed [TW-1:0]     sin_reg, cos_reg;

    logic signed [DOT_W:0]    dot_r;
    logic signed [CRS_W:0]    crx_r, cry_r, crz_r;
    logic signed [TW-1:0]     sin_next, cos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        vx1_reg   <= vec_x;
        vy1_reg   <= vec_y;
        vz1_reg   <= vec_z;
        quad1_reg <= quad_t'(quad);
        kxvx_reg  <= axis_x * vec_x;
        kyvy_reg  <= axis_y * vec_y;
        kzvz_reg  <= axis_z * vec_z;
        kyvz_reg  <= axis_y * vec_z;
        kzvy_reg  <= axis_z * vec_y;
        kzvx_reg  <= axis_z * vec_x;
        kxvz_reg  <= axis_x * vec_z;
        kxvy_reg  <= axis_x * vec_y;
        kyvx_reg  <= axis_y * vec_x;
    end

    // Round half up after each sum, dropping the 14 axis fraction bits
    always_comb
    begin
        dot_r = (DOT_W+1)'(kxvx_reg) + (DOT_W+1)'(kyvy_reg) + (DOT_W+1)'(kzvz_reg)
              + (DOT_W+1)'(RND_HALF);
        crx_r = (CRS_W+1)'(kyvz_reg) - (CRS_W+1)'(kzvy_reg) + (CRS_W+1)'(RND_HALF);
        cry_r = (CRS_W+1)'(kzvx_reg) - (CRS_W+1)'(kxvz_reg) + (CRS_W+1)'(RND_HALF);
        crz_r = (CRS_W+1)'(kxvy_reg) - (CRS_W+1)'(kyvx_reg) + (CRS_W+1)'(RND_HALF);
    end

    always_comb
    begin
        case (quad1_reg)
            QUAD_0:
            begin
                sin_next = TW'(sa);
                cos_next = TW'(sb);
            end
            QUAD_1:
            begin
                sin_next = TW'(sb);
                cos_next = -TW'(sa);
            end
            QUAD_2:
            begin
                sin_next = -TW'(sa);
                cos_next = -TW'(sb);
            end
            QUAD_3:
            begin
                sin_next = -TW'(sb);
                cos_next = TW'(sa);
            end
            default:
            begin
                sin_next = TW'(sa);
                cos_next = TW'(sb);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        vx2_reg <= vx1_reg;
        vy2_reg <= vy1_reg;
        vz2_reg <= vz1_reg;
        d_reg   <= D_W'(dot_r >>> FRAC);
        crx_reg <= CR_W'(crx_r >>> FRAC);
        cry_reg <= CR_W'(cry_r >>> FRAC);
        crz_reg <= CR_W'(crz_r >>> FRAC);
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign out_valid = v2_reg;
    assign out_vx    = vx2_reg;
    assign out_vy    = vy2_reg;
    assign out_vz    = vz2_reg;
    assign out_d     = d_reg;
    assign out_crx   = crx_reg;
    assign out_cry   = cry_reg;
    assign out_crz   = crz_reg;
    assign out_sin   = sin_reg;
    assign out_cos   = cos_reg;

endmodule

FILE: src/avr_blend.sv
// ============================================================================
// avr_blend - Rodrigues blend, rounding and saturation
// Three stages: first products, the (1 - cos) product, then the final sum,
// rounding and clamp to the output range.
// ============================================================================
module avr_blend
    import avr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [CW-1:0]    vx,
    input  logic signed [CW-1:0]    vy,
    input  logic signed [CW-1:0]    vz,
    input  logic signed [D_W-1:0]   d,
    input  logic signed [CR_W-1:0]  crx,
    input  logic signed [CR_W-1:0]  cry,
    input  logic signed [CR_W-1:0]  crz,
    input  logic signed [TW-1:0]    sin_v,
    input  logic signed [TW-1:0]    cos_v,
    input  logic signed [AW-1:0]    axis_x,
    input  logic signed [AW-1:0]    axis_y,
    input  logic signed [AW-1:0]    axis_z,
    output logic                    out_valid,
    output logic signed [CW-1:0]    out_x,
    output logic signed [CW-1:0]    out_y,
    output logic signed [CW-1:0]    out_z,
    output logic                    out_sat
);

    localparam logic signed [R_W-1:0] SAT_HI = R_W'(OUT_MAX);
    localparam logic signed [R_W-1:0] SAT_LO = ~SAT_HI;

    // Stage three
    logic                     v3_reg;
    logic signed [P1_W-1:0]   p1x3_reg, p1y3_reg, p1z3_reg;
    logic signed [P2_W-1:0]   p2x3_reg, p2y3_reg, p2z3_reg;
    logic signed [P3_W-1:0]   p3x3_reg, p3y3_reg, p3z3_reg;
    logic signed [OM_W-1:0]   om3_reg;

    // Stage four
    logic                     v4_reg;
    logic signed [P1_W-1:0]   p1x4_reg, p1y4_reg, p1z4_reg;
    logic signed [P2_W-1:0]   p2x4_reg, p2y4_reg, p2z4_reg;
    logic signed [P4_W-1:0]   p4x4_reg, p4y4_reg, p4z4_reg;

    // Stage five
    logic                     v5_reg;
    logic signed [CW-1:0]     rx_reg, ry_reg, rz_reg;
    logic                     sat_reg;

    logic signed [P3_W:0]     kdx_r, kdy_r, kdz_r;
    logic signed [KD_W-1:0]   kdx, kdy, kdz;
    logic signed [ACC_W:0]    accx_r, accy_r, accz_r;
    logic signed [R_W-1:0]    rx, ry, rz;
    logic signed [CW-1:0]     rx_next, ry_next, rz_next;
    logic                     satx, saty, satz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1x3_reg <= vx * cos_v;
        p1y3_reg <= vy * cos_v;
        p1z3_reg <= vz * cos_v;
        p2x3_reg <= crx * sin_v;
        p2y3_reg <= cry * sin_v;
        p2z3_reg <= crz * sin_v;
        p3x3_reg <= axis_x * d;
        p3y3_reg <= axis_y * d;
        p3z3_reg <= axis_z * d;
        om3_reg  <= OM_W'(ONE_Q14) - OM_W'(cos_v);
    end

    always_comb
    begin
        kdx_r = (P3_W+1)'(p3x3_reg) + (P3_W+1)'(RND_HALF);
        kdy_r = (P3_W+1)'(p3y3_reg) + (P3_W+1)'(RND_HALF);
        kdz_r = (P3_W+1)'(p3z3_reg) + (P3_W+1)'(RND_HALF);
        kdx   = KD_W'(kdx_r >>> FRAC);
        kdy   = KD_W'(kdy_r >>> FRAC);
        kdz   = KD_W'(kdz_r >>> FRAC);
    end

    always_ff @(posedge clk)
    begin
        p1x4_reg <= p1x3_reg;
        p1y4_reg <= p1y3_reg;
        p1z4_reg <= p1z3_reg;
        p2x4_reg <= p2x3_reg;
        p2y4_reg <= p2y3_reg;
        p2z4_reg <= p2z3_reg;
        p4x4_reg <= kdx * om3_reg;
        p4y4_reg <= kdy * om3_reg;
        p4z4_reg <= kdz * om3_reg;
    end

    // Sum, round half up, clamp
    always_comb
    begin
        accx_r = (ACC_W+1)'(p1x4_reg) + (ACC_W+1)'(p2x4_reg) + (ACC_W+1)'(p4x4_reg)
               + (ACC_W+1)'(RND_HALF);
        accy_r = (ACC_W+1)'(p1y4_reg) + (ACC_W+1)'(p2y4_reg) + (ACC_W+1)'(p4y4_reg)
               + (ACC_W+1)'(RND_HALF);
        accz_r = (ACC_W+1)'(p1z4_reg) + (ACC_W+1)'(p2z4_reg) + (ACC_W+1)'(p4z4_reg)
               + (ACC_W+1)'(RND_HALF);
        rx = R_W'(accx_r >>> FRAC);
        ry = R_W'(accy_r >>> FRAC);
        rz = R_W'(accz_r >>> FRAC);

        satx = (rx > SAT_HI) || (rx < SAT_LO);
        saty = (ry > SAT_HI) || (ry < SAT_LO);
        satz = (rz > SAT_HI) || (rz < SAT_LO);

        rx_next = (rx > SAT_HI) ? OUT_MAX : ((rx < SAT_LO) ? OUT_MIN : CW'(rx));
        ry_next = (ry > SAT_HI) ? OUT_MAX : ((ry < SAT_LO) ? OUT_MIN : CW'(ry));
        rz_next = (rz > SAT_HI) ? OUT_MAX : ((rz < SAT_LO) ? OUT_MIN : CW'(rz));
    end

    always_ff @(posedge clk)
    begin
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        rz_reg  <= rz_next;
        sat_reg <= satx | saty | satz;
    end

    assign out_valid = v5_reg;
    assign out_x     = rx_reg;
    assign out_y     = ry_reg;
    assign out_z     = rz_reg;
    assign out_sat   = sat_reg;

endmodule

FILE: src/axis_angle_vector_rotator_top.sv
// ============================================================================
// axis_angle_vector_rotator_top - Rodrigues rotation of a vector about an axis
// Rotates each Q4.12 vector about the configured Q1.14 axis by its angle and
// returns the saturated result after a fixed latency.
// ============================================================================
//
// The block takes one word every clock cycle and never pushes back: busy is
// held low, so any cycle with start high accepts a word. Each word passes
// through the registered stages and comes out with done high for one cycle;
// the pipeline is fixed-length and the receiver has no way to stall it, so
// capture rot_x, rot_y, rot_z and saturated whenever done is high. Its
// stages are the sine ROM read in parallel with the nine axis products, the
// dot and cross rounding, the blend products, the (1 - cos) product and the
// final sum with saturation. Write the axis registers (index 0..2 = x, y, z,
// Q1.14, reset to the x axis) only when no word is in flight; indexes beyond
// the list are dropped. The axis is used as written, with no normalisation.
//
module axis_angle_vector_rotator_top
    import avr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [CW-1:0]    vec_x,
    input  logic signed [CW-1:0]    vec_y,
    input  logic signed [CW-1:0]    vec_z,
    input  logic [ANGLE_W-1:0]      angle,
    output logic                    done,
    output logic signed [CW-1:0]    rot_x,
    output logic signed [CW-1:0]    rot_y,
    output logic signed [CW-1:0]    rot_z,
    output logic                    saturated,
    input  logic                    wr_en,
    input  logic [REG_IDX_W-1:0]    wr_index,
    input  logic [AW-1:0]           wr_data
);

    logic signed [AW-1:0]   axis_x_reg, axis_x_next;
    logic signed [AW-1:0]   axis_y_reg, axis_y_next;
    logic signed [AW-1:0]   axis_z_reg, axis_z_next;

    logic                   accept;
    logic [SINE_W-1:0]      sa, sb;

    logic                   f_valid;
    logic signed [CW-1:0]   f_vx, f_vy, f_vz;
    logic signed [D_W-1:0]  f_d;
    logic signed [CR_W-1:0] f_crx, f_cry, f_crz;
    logic signed [TW-1:0]   f_sin, f_cos;

    // Never stall the input side: a new word may enter every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Axis registers: take the write in the cycle it arrives, drop bad indexes
    always_comb
    begin
        axis_x_next = axis_x_reg;
        axis_y_next = axis_y_reg;
        axis_z_next = axis_z_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_AXIS_X: axis_x_next = wr_data;
                REG_AXIS_Y: axis_y_next = wr_data;
                REG_AXIS_Z: axis_z_next = wr_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_x_reg <= AXIS_X_RST;
            axis_y_reg <= AXIS_Y_RST;
            axis_z_reg <= AXIS_Z_RST;
        end
        else
        begin
            axis_x_reg <= axis_x_next;
            axis_y_reg <= axis_y_next;
            axis_z_reg <= axis_z_next;
        end
    end

    // Sine and cosine magnitudes, ready alongside the first product stage
    avr_sine_rom u_sine_rom (
        .clk   (clk),
        .angle (angle),
        .sa    (sa),
        .sb    (sb)
    );

    // Products, dot and cross terms, quadrant resolve
    avr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .quad      (angle[ANGLE_W-1:PHASE_W]),
        .axis_x    (axis_x_reg),
        .axis_y    (axis_y_reg),
        .axis_z    (axis_z_reg),
        .sa        (sa),
        .sb        (sb),
        .out_valid (f_valid),
        .out_vx    (f_vx),
        .out_vy    (f_vy),
        .out_vz    (f_vz),
        .out_d     (f_d),
        .out_crx   (f_crx),
        .out_cry   (f_cry),
        .out_crz   (f_crz),
        .out_sin   (f_sin),
        .out_cos   (f_cos)
    );

    // Blend the three Rodrigues terms, round and clamp
    avr_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .vx        (f_vx),
        .vy        (f_vy),
        .vz        (f_vz),
        .d         (f_d),
        .crx       (f_crx),
        .cry       (f_cry),
        .crz       (f_crz),
        .sin_v     (f_sin),
        .cos_v     (f_cos),
        .axis_x    (axis_x_reg),
        .axis_y    (axis_y_reg),
        .axis_z    (axis_z_reg),
        .out_valid (done),
        .out_x     (rot_x),
        .out_y     (rot_y),
        .out_z     (rot_z),
        .out_sat   (saturated)
    );

    // Every accepted word leaves after the fixed latency
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted word did not produce a result");

    // No result without a matching word accepted earlier
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching accepted word");

    // The clamp flag means some component sits at a range limit
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |->
            (rot_x == OUT_MAX) || (rot_x == OUT_MIN) ||
            (rot_y == OUT_MAX) || (rot_y == OUT_MIN) ||
            (rot_z == OUT_MAX) || (rot_z == OUT_MIN))
        else $error("saturated set with no component at a limit");

endmodule
